// File: hdl/http_get_query_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// HTTP GET query parser assertion macros
// Implication and never-true checks, empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef HTTP_GET_QUERY_PARSER_UNIT_ASSERT_SVH
`define HTTP_GET_QUERY_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HGQP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hgqp implication check failed");
`define HGQP_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("hgqp forbidden condition seen");
`else
`define HGQP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HGQP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: hdl/hgqp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP GET query parser package
// Shared types, codes, limits and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hgqp_pkg;

	localparam int KEY_LEN       = 16;
	localparam int VALUE_LEN     = 16;
	localparam int MAX_PAIRS     = 16;
	localparam int PREFIX_LEN    = 5;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] PAGE_CAP_RESET = 8'd35;
	localparam logic [2:0] PREFIX_LAST    = 3'(PREFIX_LEN - 1);

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DEL   = 8'h7f;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_BSL   = 8'h5c;

	typedef enum logic [2:0] {
		PH_PREFIX = 3'd0,
		PH_PAGE   = 3'd1,
		PH_KEY    = 3'd2,
		PH_VALUE  = 3'd3,
		PH_PCT    = 3'd4,
		PH_PCT1   = 3'd5,
		PH_LOOK   = 3'd6,
		PH_BLANK  = 3'd7
	} phase_t;

	typedef enum logic [3:0] {
		EV_NONE     = 4'd0,
		EV_PAGE     = 4'd1,
		EV_KEY      = 4'd2,
		EV_VALUE    = 4'd3,
		EV_PAGE_END = 4'd4,
		EV_KEY_END  = 4'd5,
		EV_PAIR_END = 4'd6,
		EV_DONE     = 4'd7,
		EV_FAIL     = 4'd8
	} event_t;

	typedef enum logic [2:0] {
		RS_NONE      = 3'd0,
		RS_PAGE_LONG = 3'd1,
		RS_KEY_LONG  = 3'd2,
		RS_KEY_AMP   = 3'd3,
		RS_VAL_LONG  = 3'd4,
		RS_VAL_CHAR  = 3'd5,
		RS_CLOSED    = 3'd6
	} reason_t;

	typedef enum logic [3:0] {
		CK_OTHER = 4'd0,
		CK_QMARK = 4'd1,
		CK_SPACE = 4'd2,
		CK_LF    = 4'd3,
		CK_CR    = 4'd4,
		CK_AMP   = 4'd5,
		CK_EQ    = 4'd6,
		CK_PLUS  = 4'd7,
		CK_PCT   = 4'd8
	} char_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       closed;
		char_kind_t kind;
		logic       printable;
		logic       is_hex;
		logic [3:0] hex_val;
	} class_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic [3:0] idx;
		logic [4:0] count;
		reason_t    reason;
	} result_t;

	function automatic char_kind_t char_kind(input logic [7:0] c);
		char_kind_t k;
		unique case (c)
			8'h3f:   k = CK_QMARK;
			8'h20:   k = CK_SPACE;
			8'h0a:   k = CK_LF;
			8'h0d:   k = CK_CR;
			8'h26:   k = CK_AMP;
			8'h3d:   k = CK_EQ;
			8'h2b:   k = CK_PLUS;
			8'h25:   k = CK_PCT;
			default: k = CK_OTHER;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] n);
		logic [7:0] c;
		unique case (n)
			3'd0:    c = 8'h47;
			3'd1:    c = 8'h45;
			3'd2:    c = 8'h54;
			3'd3:    c = 8'h20;
			default: c = 8'h2f;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/hgqp_front.sv
// ----------------------------------------------------------------------------
// HTTP GET query parser front
// Accept input transfers and classify each byte for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hgqp_front (
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [7:0]      s_tdata,
	input  wire logic [0:0]      s_tuser,
	input  wire logic            q_full,
	output logic                 q_push,
	output hgqp_pkg::class_t     q_item
);
	import hgqp_pkg::*;

	logic [7:0] c;

	assign c        = s_tdata;
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item           = '0;
		q_item.data      = c;
		q_item.closed    = s_tuser[0];
		q_item.kind      = char_kind(c);
		q_item.printable = (c > 8'd32) && (c < 8'd127);
		priority if (c >= 8'h30 && c <= 8'h39) begin
			q_item.is_hex  = 1'b1;
			q_item.hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			q_item.is_hex  = 1'b1;
			q_item.hex_val = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			q_item.is_hex  = 1'b1;
			q_item.hex_val = 4'(c - 8'h57);
		end else begin
			q_item.is_hex  = 1'b0;
			q_item.hex_val = 4'd0;
		end
	end

endmodule

`default_nettype wire

// File: hdl/hgqp_queue.sv
// ----------------------------------------------------------------------------
// HTTP GET query parser queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hgqp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hgqp_pkg::class_t push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output hgqp_pkg::class_t      head
);
	import hgqp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

	class_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == DEPTH_CNT);
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/hgqp_back.sv
// ----------------------------------------------------------------------------
// HTTP GET query parser back end
// Run the request-line state machine and hold one result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module hgqp_back #(
	parameter int KEY_LEN   = hgqp_pkg::KEY_LEN,
	parameter int VALUE_LEN = hgqp_pkg::VALUE_LEN,
	parameter int MAX_PAIRS = hgqp_pkg::MAX_PAIRS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       page_capacity,
	input  wire logic             q_not_empty,
	input  wire hgqp_pkg::class_t q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output hgqp_pkg::result_t     out_item
);
	import hgqp_pkg::*;

	localparam logic [4:0] KEY_LIMIT   = 5'(KEY_LEN - 1);
	localparam logic [4:0] VALUE_LIMIT = 5'(VALUE_LEN - 1);
	localparam logic [4:0] PAIR_LIMIT  = 5'(MAX_PAIRS - 1);

	phase_t     phase_q,  phase_d;
	logic [2:0] pfx_q,    pfx_d;
	logic [7:0] page_q,   page_d;
	logic [4:0] key_q,    key_d;
	logic [4:0] val_q,    val_d;
	logic [4:0] pairs_q,  pairs_d;
	logic [3:0] nib_q,    nib_d;
	logic       out_valid_q;
	result_t    out_q;

	logic       go;
	logic       finish;
	event_t     ev;
	logic [7:0] data;
	reason_t    reason;
	logic [7:0] decoded;
	logic       bad_decoded;
	logic       prefix_hit;

	assign go          = q_not_empty && (!out_valid_q || out_ready);
	assign q_pop       = go;
	assign out_valid   = out_valid_q;
	assign out_item    = out_q;
	assign decoded     = {nib_q, q_head.hex_val};
	assign bad_decoded = (decoded < CHAR_SPACE) || (decoded == CHAR_DEL)
		|| (decoded == CHAR_QUOTE) || (decoded == CHAR_BSL);
	assign prefix_hit  = (q_head.data == prefix_char(pfx_q));

	always_comb begin
		ev     = EV_NONE;
		data   = 8'd0;
		reason = RS_NONE;
		finish = 1'b0;
		if (q_head.closed) begin
			ev     = EV_FAIL;
			reason = RS_CLOSED;
			finish = 1'b1;
		end else begin
			unique case (phase_q)
				PH_PREFIX: ;
				PH_PAGE: begin
					if (q_head.kind == CK_QMARK || q_head.kind == CK_SPACE
						|| q_head.kind == CK_LF) begin
						ev = EV_PAGE_END;
					end else if (q_head.printable) begin
						if ({1'b0, page_q} + 9'd1 >= {1'b0, page_capacity}) begin
							ev     = EV_FAIL;
							reason = RS_PAGE_LONG;
							finish = 1'b1;
						end else begin
							ev   = EV_PAGE;
							data = q_head.data;
						end
					end
				end
				PH_KEY: begin
					priority if (q_head.kind == CK_SPACE || q_head.kind == CK_LF) begin
						ev = EV_NONE;
					end else if (q_head.kind == CK_AMP) begin
						ev     = EV_FAIL;
						reason = RS_KEY_AMP;
						finish = 1'b1;
					end else if (q_head.kind == CK_EQ) begin
						ev = EV_KEY_END;
					end else if (q_head.printable) begin
						if (key_q >= KEY_LIMIT) begin
							ev     = EV_FAIL;
							reason = RS_KEY_LONG;
							finish = 1'b1;
						end else begin
							ev   = EV_KEY;
							data = q_head.data;
						end
					end else begin
						ev = EV_NONE;
					end
				end
				PH_VALUE, PH_PCT, PH_PCT1: begin
					priority if (q_head.kind == CK_SPACE || q_head.kind == CK_AMP) begin
						if (q_head.kind == CK_AMP && pairs_q >= PAIR_LIMIT) begin
							ev     = EV_DONE;
							finish = 1'b1;
						end else begin
							ev = EV_PAIR_END;
						end
					end else if (q_head.printable) begin
						priority if (val_q >= VALUE_LIMIT) begin
							ev     = EV_FAIL;
							reason = RS_VAL_LONG;
							finish = 1'b1;
						end else if (phase_q == PH_PCT) begin
							ev = EV_NONE;
						end else if (phase_q == PH_PCT1) begin
							if (q_head.is_hex) begin
								ev   = EV_VALUE;
								data = bad_decoded ? CHAR_SPACE : decoded;
							end
						end else if (q_head.kind == CK_PLUS) begin
							ev   = EV_VALUE;
							data = CHAR_SPACE;
						end else if (q_head.kind == CK_PCT) begin
							ev = EV_NONE;
						end else begin
							ev   = EV_VALUE;
							data = q_head.data;
						end
					end else begin
						ev     = EV_FAIL;
						reason = RS_VAL_CHAR;
						finish = 1'b1;
					end
				end
				PH_LOOK: ;
				PH_BLANK: begin
					if (q_head.kind == CK_LF) begin
						ev     = EV_DONE;
						finish = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		pfx_d   = pfx_q;
		page_d  = page_q;
		key_d   = key_q;
		val_d   = val_q;
		pairs_d = pairs_q;
		nib_d   = nib_q;
		if (finish) begin
			phase_d = PH_PREFIX;
			pfx_d   = '0;
			page_d  = '0;
			key_d   = '0;
			val_d   = '0;
			pairs_d = '0;
			nib_d   = '0;
		end else begin
			unique case (phase_q)
				PH_PREFIX: begin
					if (prefix_hit) begin
						pfx_d = pfx_q + 3'd1;
						if (pfx_q == PREFIX_LAST) begin
							phase_d = PH_PAGE;
						end
					end
				end
				PH_PAGE: begin
					if (q_head.kind == CK_QMARK) begin
						phase_d = PH_KEY;
					end else if (q_head.kind == CK_SPACE) begin
						phase_d = PH_LOOK;
					end else if (q_head.kind == CK_LF) begin
						phase_d = PH_BLANK;
					end
					if (ev == EV_PAGE) begin
						page_d = page_q + 8'd1;
					end
				end
				PH_KEY: begin
					if (q_head.kind == CK_SPACE) begin
						phase_d = PH_LOOK;
					end else if (q_head.kind == CK_LF) begin
						phase_d = PH_BLANK;
					end else if (q_head.kind == CK_EQ) begin
						phase_d = PH_VALUE;
					end
					if (ev == EV_KEY) begin
						key_d = key_q + 5'd1;
					end
				end
				PH_VALUE, PH_PCT, PH_PCT1: begin
					if (ev == EV_PAIR_END) begin
						pairs_d = pairs_q + 5'd1;
						if (q_head.kind == CK_AMP) begin
							key_d   = '0;
							val_d   = '0;
							phase_d = PH_KEY;
						end else begin
							phase_d = PH_LOOK;
						end
					end else begin
						if (phase_q == PH_PCT) begin
							if (q_head.is_hex) begin
								nib_d   = q_head.hex_val;
								phase_d = PH_PCT1;
							end else begin
								phase_d = PH_VALUE;
							end
						end else if (phase_q == PH_PCT1) begin
							phase_d = PH_VALUE;
						end else if (q_head.kind == CK_PCT) begin
							phase_d = PH_PCT;
						end
						if (ev == EV_VALUE) begin
							val_d = val_q + 5'd1;
						end
					end
				end
				PH_LOOK: begin
					if (q_head.kind == CK_LF) begin
						phase_d = PH_BLANK;
					end
				end
				PH_BLANK: begin
					if (q_head.kind != CK_CR) begin
						phase_d = PH_LOOK;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREFIX;
			pfx_q       <= '0;
			page_q      <= '0;
			key_q       <= '0;
			val_q       <= '0;
			pairs_q     <= '0;
			nib_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (go) begin
			phase_q     <= phase_d;
			pfx_q       <= pfx_d;
			page_q      <= page_d;
			key_q       <= key_d;
			val_q       <= val_d;
			pairs_q     <= pairs_d;
			nib_q       <= nib_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q.ev     <= ev;
			out_q.data   <= data;
			out_q.idx    <= pairs_q[3:0];
			out_q.count  <= finish ? pairs_q : pairs_d;
			out_q.reason <= reason;
		end
	end

endmodule

`default_nettype wire

// File: hdl/http_get_query_parser_unit.sv
// ----------------------------------------------------------------------------
// HTTP GET query parser unit
// Request-line parser emitting page, key and decoded value bytes as events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one request byte per transfer in s_tdata, s_tuser[0] set
//   when the link closed (byte ignored, request fails).
//   Master stream: exactly one result per input transfer, in order; the
//   event code in m_tuser, byte, pair index, pair count and fail reason in
//   m_tdata.
//   Config channel: cfg_data writes the page capacity; write only while no
//   transfer is in flight.
//   Path: each input byte is written into the queue, then its result is
//   registered in the output register that drives m_tvalid and m_tdata.
//   Throughput: one byte per cycle; the state machine retires one queued
//   byte each cycle the output register is free or being drained.
//   Stall: a stalled receiver holds the output register, the two-entry
//   queue fills, then s_tready drops until the receiver takes a transfer.
//   Reset: parser returns to waiting for the GET prefix, queue and output
//   empty, page capacity 35.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_get_query_parser_unit_assert.svh"

module http_get_query_parser_unit #(
	parameter int KEY_LEN   = hgqp_pkg::KEY_LEN,
	parameter int VALUE_LEN = hgqp_pkg::VALUE_LEN,
	parameter int MAX_PAIRS = hgqp_pkg::MAX_PAIRS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [0:0]  s_tuser,   // [0] link_closed
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] data_byte, [11:8] pair_index,
	                                    // [16:12] pair_count, [19:17] fail_reason,
	                                    // [23:20] zero
	output logic [3:0]       m_tuser,   // [3:0] event_res
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);
	import hgqp_pkg::*;

	localparam logic [4:0] PAIR_MAX = 5'(MAX_PAIRS);

	logic [7:0] page_capacity_q;
	logic       q_full;
	logic       q_push;
	class_t     q_item;
	logic       q_pop;
	logic       q_not_empty;
	class_t     q_head;
	result_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_capacity_q <= PAGE_CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			page_capacity_q <= cfg_data;
		end
	end

	hgqp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	hgqp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	hgqp_back #(
		.KEY_LEN   (KEY_LEN),
		.VALUE_LEN (VALUE_LEN),
		.MAX_PAIRS (MAX_PAIRS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.page_capacity (page_capacity_q),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_item      (res)
	);

	assign m_tuser = res.ev;
	assign m_tdata = {4'd0, res.reason, res.count, res.idx, res.data};

	`HGQP_ASSERT_IMP(a_fail_reason, clk, arst_n, m_tvalid,
		((m_tuser == EV_FAIL) == (m_tdata[19:17] != RS_NONE)))
	`HGQP_ASSERT_IMP(a_data_kind, clk, arst_n,
		m_tvalid && m_tuser != EV_PAGE && m_tuser != EV_KEY && m_tuser != EV_VALUE,
		m_tdata[7:0] == 8'd0)
	`HGQP_ASSERT_IMP(a_pair_end_count, clk, arst_n, m_tvalid && m_tuser == EV_PAIR_END,
		m_tdata[15:12] == m_tdata[11:8] + 4'd1)
	`HGQP_ASSERT_NEVER(a_pair_bound, clk, arst_n, m_tvalid && m_tdata[16:12] > PAIR_MAX)

endmodule

`default_nettype wire
